// ----- rtl/hbdt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbdt_pkg
// shared widths, register indexes and types of the h-bridge dead-time drive
// ----------------------------------------------------------------------------
package hbdt_pkg;

  localparam int SPEED_W = 17;
  localparam int LEVEL_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] DEADZONE_RESET    = 16'd0;
  localparam logic [CFG_W-1:0] SPEED_LIMIT_RESET = 16'hFFFF;
  localparam logic [CFG_W-1:0] DEADTIME_RESET    = 16'd50;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE    = 2'd0,
    REG_SPEED_LIMIT = 2'd1,
    REG_REVERSED    = 2'd2,
    REG_DEADTIME    = 2'd3
  } cfg_reg_t;

  // input opcodes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_a;
    logic [LEVEL_W-1:0] level_b;
    logic               in_dead_time;
  } drive_t;

endpackage

// ----- rtl/hbdt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbdt interfaces
// valid/ready channels for speed commands and leg drive levels
// ----------------------------------------------------------------------------
interface hbdt_cmd_if import hbdt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic signed [SPEED_W-1:0] speed;

  modport source (output valid, output opcode, output speed, input ready);
  modport sink (input valid, input opcode, input speed, output ready);
endinterface

interface hbdt_drive_if import hbdt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level_a;
  logic [LEVEL_W-1:0] level_b;
  logic               in_dead_time;

  modport source (output valid, output level_a, output level_b, output in_dead_time,
                  input ready);
  modport sink (input valid, input level_a, input level_b, input in_dead_time,
                output ready);
endinterface

// ----- rtl/h_bridge_drive_with_dead_time_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h_bridge_drive_with_dead_time_top
// h-bridge leg drive with deadzone, clamp, reverse and dead-time insertion
// ----------------------------------------------------------------------------
// each cmd transfer's drive result is registered in the result register, or
// in the skid entry while that register stalls; one transfer per cycle while
// skid is empty. a two-entry output buffer (result register plus skid) keeps
// cmd ready while one finished result waits on the drive side
// reset (rst, synchronous): speed and dead-time counter cleared, registers
// to deadzone 0, speed limit 65535, reversed 0, deadtime_ticks 50
module h_bridge_drive_with_dead_time_top import hbdt_pkg::*; #(
  parameter int LEVEL_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  hbdt_cmd_if.sink             cmd,
  hbdt_drive_if.source         drive,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // largest duty level that LEVEL_WIDTH bits hold, seen through a 16 bit port
  localparam logic [LEVEL_W-1:0] LEVEL_TOP = (LEVEL_WIDTH >= LEVEL_W) ?
      {LEVEL_W{1'b1}} : LEVEL_W'((64'd1 << LEVEL_WIDTH) - 64'd1);

  // configuration registers
  logic [CFG_W-1:0] deadzone;
  logic [CFG_W-1:0] speed_limit;
  logic             reversed;
  logic [CFG_W-1:0] deadtime_ticks;

  // state: pending speed kept as sign and magnitude, plus dead-time counter
  logic               cur_neg;
  logic [LEVEL_W-1:0] cur_mag;
  logic [CFG_W-1:0]   dead_remaining;

  logic               cur_neg_next;
  logic [LEVEL_W-1:0] cur_mag_next;
  logic [CFG_W-1:0]   dead_remaining_next;

  // output buffer
  logic   out_valid;
  drive_t out_data;
  logic   skid_valid;
  drive_t skid_data;

  logic   accept;
  logic   out_fire;
  drive_t result;

  // command shaping
  logic [SPEED_W-1:0] req_mag;
  logic [LEVEL_W-1:0] clamp_mag;
  logic               in_zone;
  logic               new_neg;
  logic [LEVEL_W-1:0] sat_mag;

  assign cmd.ready = !skid_valid;
  assign accept    = cmd.valid && cmd.ready;
  assign out_fire  = out_valid && drive.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone       <= DEADZONE_RESET;
      speed_limit    <= SPEED_LIMIT_RESET;
      reversed       <= 1'b0;
      deadtime_ticks <= DEADTIME_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEADZONE:    deadzone       <= cfg_data;
        REG_SPEED_LIMIT: speed_limit    <= cfg_data;
        REG_REVERSED:    reversed       <= cfg_data[0];
        REG_DEADTIME:    deadtime_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    // magnitude of the request, -65536 gives 17'h10000
    req_mag   = cmd.speed[SPEED_W-1] ? SPEED_W'(-cmd.speed) : SPEED_W'(cmd.speed);
    in_zone   = (req_mag <= {1'b0, deadzone});
    clamp_mag = (req_mag > {1'b0, speed_limit}) ? speed_limit : req_mag[LEVEL_W-1:0];
    if (in_zone) begin
      clamp_mag = '0;
    end
    // zero is always forward
    new_neg = (cmd.speed[SPEED_W-1] ^ reversed) && (clamp_mag != '0);

    cur_neg_next        = cur_neg;
    cur_mag_next        = cur_mag;
    dead_remaining_next = dead_remaining;
    if (cmd.opcode == OP_COMMAND) begin
      // direction change from a nonzero pending speed reloads dead time
      if (cur_mag != '0 && cur_neg != new_neg) begin
        dead_remaining_next = deadtime_ticks;
      end
      cur_neg_next = new_neg;
      cur_mag_next = clamp_mag;
    end else if (dead_remaining != '0) begin
      dead_remaining_next = dead_remaining - 1'b1;
    end

    sat_mag = (cur_mag_next > LEVEL_TOP) ? LEVEL_TOP : cur_mag_next;

    result = '0;
    if (dead_remaining_next != '0) begin
      result.in_dead_time = 1'b1;
    end else if (cur_neg_next) begin
      result.level_b = sat_mag;
    end else begin
      result.level_a = sat_mag;
    end
  end

  // state advances on every cmd transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_neg        <= 1'b0;
      cur_mag        <= '0;
      dead_remaining <= '0;
    end else if (accept) begin
      cur_neg        <= cur_neg_next;
      cur_mag        <= cur_mag_next;
      dead_remaining <= dead_remaining_next;
    end
  end

  // result register with skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (accept) begin
      skid_data <= result;
    end
  end

  assign drive.valid        = out_valid;
  assign drive.level_a      = out_data.level_a;
  assign drive.level_b      = out_data.level_b;
  assign drive.in_dead_time = out_data.in_dead_time;

endmodule

// ----- rtl/hbdt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbdt_checker
// port-level checks of the h-bridge drive, bound to the top level
// ----------------------------------------------------------------------------
module hbdt_checker import hbdt_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               cmd_ready,
  input logic               drive_valid,
  input logic               drive_ready,
  input logic [LEVEL_W-1:0] level_a,
  input logic [LEVEL_W-1:0] level_b,
  input logic               in_dead_time
);

  // never both legs driven at once
  a_legs_exclusive: assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> (level_a == '0 || level_b == '0))
    else $error("both h-bridge legs driven");

  // dead time holds both legs off
  a_dead_time_off: assert property (@(posedge clk) disable iff (rst)
    (drive_valid && in_dead_time) |-> (level_a == '0 && level_b == '0))
    else $error("leg driven during dead time");

  // cmd only backs off when a result is waiting
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> drive_valid)
    else $error("cmd stalled with empty output");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (drive_valid && !drive_ready) |=>
      (drive_valid && $stable(level_a) && $stable(level_b) && $stable(in_dead_time)))
    else $error("stalled result changed");

  // nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !drive_valid)
    else $error("result valid after reset");

endmodule

bind h_bridge_drive_with_dead_time_top hbdt_checker u_hbdt_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_ready    (cmd.ready),
  .drive_valid  (drive.valid),
  .drive_ready  (drive.ready),
  .level_a      (drive.level_a),
  .level_b      (drive.level_b),
  .in_dead_time (drive.in_dead_time)
);
